/* design/csls_pkg.sv */
// shared constants, codes and fixed-point helpers of the cholesky solver
package csls_pkg;

  localparam int MAX_ORDER  = 16;
  localparam int EMIT_BOUND = (MAX_ORDER < 16) ? MAX_ORDER : 16;
  localparam int ORDER_W    = $clog2(MAX_ORDER);
  localparam int CNT_W      = $clog2(EMIT_BOUND);
  localparam int ADDR_W     = 2 * ORDER_W;
  localparam int MAT_DEPTH  = 1 << ADDR_W;
  localparam int NUM_W      = 49;
  localparam int RAD_W      = 48;
  localparam int ROOT_W     = 24;

  typedef enum logic [1:0] {
    CMD_LOAD_MAT = 2'd0,
    CMD_LOAD_VEC = 2'd1,
    CMD_SOLVE    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  localparam logic signed [63:0] SMAX64 = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [63:0] SMIN64 = 64'shffff_ffff_8000_0000;
  localparam logic signed [31:0] SMAX32 = 32'sh7fff_ffff;
  localparam logic signed [31:0] SMIN32 = 32'sh8000_0000;

  // saturate a wide signed value to q16.16
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > SMAX64) return SMAX32;
    if (x < SMIN64) return SMIN32;
    return x[31:0];
  endfunction

  // round a raw 64-bit product back to q16.16
  function automatic logic signed [31:0] qmul(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + 64'sd32768) >>> 16;
    return sat32(t);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CNT_W-1:0] r,
                                                input logic [CNT_W-1:0] c);
    return {ORDER_W'(r), ORDER_W'(c)};
  endfunction

  // last index of the solved system from the size register
  function automatic logic [CNT_W-1:0] order_m1(input logic [4:0] size);
    if (size == 5'd0) return '0;
    if (int'(size) > EMIT_BOUND) return CNT_W'(EMIT_BOUND - 1);
    return CNT_W'(size - 5'd1);
  endfunction

endpackage

/* design/csls_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module csls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/csls_div.sv */
// restoring divider, one quotient bit per cycle
module csls_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [csls_pkg::NUM_W-1:0] num_i,
  input  logic [31:0]               den_i,
  output logic                      done_o,
  output logic [csls_pkg::NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(csls_pkg::NUM_W);

  logic                       busy_q;
  logic                       done_q;
  logic [CW-1:0]              cnt_q;
  logic [31:0]                rem_q;
  logic [31:0]                den_q;
  logic [csls_pkg::NUM_W-1:0] quo_q;
  logic [32:0]                rem_sh;
  logic                       fits;

  assign rem_sh = {rem_q, quo_q[csls_pkg::NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(csls_pkg::NUM_W - 1);
        rem_q  <= '0;
        den_q  <= den_i;
        quo_q  <= num_i;
      end else if (busy_q) begin
        rem_q <= fits ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
        quo_q <= {quo_q[csls_pkg::NUM_W-2:0], fits};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* design/csls_sqrt.sv */
// integer square root, one root bit per cycle
module csls_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [csls_pkg::RAD_W-1:0]  rad_i,
  output logic                       done_o,
  output logic [csls_pkg::ROOT_W-1:0] root_o
);

  localparam int CW = $clog2(csls_pkg::ROOT_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [csls_pkg::RAD_W-1:0]  rad_q;
  logic [25:0]                 rem_q;
  logic [csls_pkg::ROOT_W-1:0] root_q;
  logic [27:0]                 rem_sh;
  logic [27:0]                 trial;
  logic                        fits;

  assign rem_sh = {rem_q, rad_q[csls_pkg::RAD_W-1 -: 2]};
  assign trial  = 28'({root_q, 2'b01});
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(csls_pkg::ROOT_W - 1);
        rad_q  <= rad_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[csls_pkg::RAD_W-3:0], 2'b00};
        rem_q  <= fits ? 26'(rem_sh - trial) : 26'(rem_sh);
        root_q <= {root_q[csls_pkg::ROOT_W-2:0], fits};
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

/* design/cholesky_spd_linear_solve.sv */
// top level: spd system solver by cholesky factor, triangular inverse and product
// loads are written straight into the stores and busy stays low; a solve holds busy high
// until its last result is out, over o(n^3) multiply-accumulate terms, the divisions
// (off-diagonal factor entries and reciprocals) and the square roots
// results come one per dot product, n of them, and cannot be stalled
// reset: size 16, error clear, stores undefined until written, no clearing pass
module cholesky_spd_linear_solve (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [3:0]         row_i,
  input  logic [3:0]         col_i,
  input  logic signed [31:0] value_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [4:0]         cfg_data_i,
  output logic               out_valid_o,
  output logic [3:0]         index_o,
  output logic signed [31:0] result_value_o,
  output logic               last_o,
  output logic               error_o
);

  localparam int CW = csls_pkg::CNT_W;
  localparam int AW = csls_pkg::ADDR_W;
  localparam int OW = csls_pkg::ORDER_W;
  localparam int NW = csls_pkg::NUM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DOT_RD, S_DOT_MUL, S_DOT_ACC, S_FIN_RD,
    S_FIN_EX, S_FIN_MUL, S_DIV_WAIT, S_SQRT_WAIT, S_NEXT
  } state_e;

  // solve passes in order
  typedef enum logic [2:0] {
    PH_CHOL, PH_RECIP, PH_INV, PH_HINV, PH_OUTP
  } phase_e;

  state_e             state_q;
  phase_e             phase_q;
  logic [CW-1:0]      a_q, b_q, k_q, nm1_q;
  logic [4:0]         size_q;
  logic               err_q;
  logic               neg_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] prod_q;
  logic               out_valid_q;
  logic [3:0]         index_q;
  logic signed [31:0] result_q;
  logic               last_q;

  // memory ports
  logic              m_we, v_we, w_we, h_we;
  logic [AW-1:0]     m_waddr, m_raddr, w_waddr, wa_raddr, wb_raddr, h_waddr, h_raddr;
  logic [OW-1:0]     v_waddr, v_raddr;
  logic [31:0]       w_wdata, h_wdata;
  logic [31:0]       m_rdata, v_rdata, wa_rdata, wb_rdata, h_rdata;

  // arithmetic units
  logic              div_start, div_done;
  logic [NW-1:0]     div_num, div_quo;
  logic              sq_start, sq_done;
  logic [csls_pkg::RAD_W-1:0]  sq_rad;
  logic [csls_pkg::ROOT_W-1:0] sq_root;

  logic signed [63:0] d64;
  logic signed [31:0] t32, w32, y32, mul_a, mul_b, div_sat;
  logic [31:0]        t_mag;
  logic               w_pos, d_pos, diag;
  logic [CW-1:0]      k_end, k_hinv;
  logic               accept;

  assign accept      = start && !busy;
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // working values around the finishing step of an element
  assign d64   = {{32{m_rdata[31]}}, m_rdata} - acc_q;
  assign t32   = csls_pkg::sat32(d64);
  assign t_mag = t32[31] ? (~t32 + 32'd1) : t32;
  assign w32   = wa_rdata;
  assign w_pos = !w32[31] && (w32 != 32'sd0);
  assign d_pos = !d64[63] && (d64 != 64'sd0);
  assign diag  = (a_q == b_q);
  assign y32   = csls_pkg::qmul(prod_q);
  assign k_hinv = (a_q > b_q) ? a_q : b_q;

  // divider quotient back to signed q16.16
  always_comb begin
    if (neg_q) begin
      div_sat = (div_quo >= NW'(64'h8000_0000)) ? csls_pkg::SMIN32 : 32'(-div_quo);
    end else begin
      div_sat = (div_quo > NW'(64'h7fff_ffff)) ? csls_pkg::SMAX32 : div_quo[31:0];
    end
  end

  // mac operands: vector times inverse in the last pass, factor entries otherwise
  assign mul_a = (phase_q == PH_OUTP) ? v_rdata : wa_rdata;
  assign mul_b = (phase_q == PH_OUTP) ? h_rdata : wb_rdata;

  always_comb begin
    unique case (phase_q)
      PH_CHOL: k_end = b_q - 1'b1;
      PH_INV:  k_end = a_q - 1'b1;
      default: k_end = nm1_q;
    endcase
  end

  // memory addressing and write-back
  always_comb begin
    m_we    = accept && (cmd_i == csls_pkg::CMD_LOAD_MAT) &&
              (int'(row_i) < csls_pkg::MAX_ORDER) && (int'(col_i) < csls_pkg::MAX_ORDER);
    m_waddr = {OW'(row_i), OW'(col_i)};
    m_raddr = csls_pkg::addr_of(a_q, b_q);
    v_we    = accept && (cmd_i == csls_pkg::CMD_LOAD_VEC) &&
              (int'(row_i) < csls_pkg::MAX_ORDER);
    v_waddr = OW'(row_i);
    v_raddr = OW'(k_q);
    h_raddr = csls_pkg::addr_of(k_q, a_q);
    h_waddr = csls_pkg::addr_of(a_q, b_q);
    h_we    = (state_q == S_FIN_RD) && (phase_q == PH_HINV);
    h_wdata = csls_pkg::sat32(acc_q);

    if (state_q == S_FIN_RD) begin
      wa_raddr = (phase_q == PH_CHOL) ? csls_pkg::addr_of(b_q, b_q)
                                      : csls_pkg::addr_of(a_q, a_q);
    end else begin
      wa_raddr = (phase_q == PH_HINV) ? csls_pkg::addr_of(k_q, a_q)
                                      : csls_pkg::addr_of(a_q, k_q);
    end
    wb_raddr = (phase_q == PH_CHOL) ? csls_pkg::addr_of(b_q, k_q)
                                    : csls_pkg::addr_of(k_q, b_q);

    w_waddr = (phase_q == PH_RECIP) ? csls_pkg::addr_of(a_q, a_q)
                                    : csls_pkg::addr_of(a_q, b_q);
    w_we      = 1'b0;
    w_wdata   = '0;
    div_start = 1'b0;
    div_num   = '0;
    sq_start  = 1'b0;
    sq_rad    = {t32, 16'h0000};

    unique case (state_q)
      S_FIN_EX: begin
        unique case (phase_q)
          PH_CHOL: begin
            if (diag) begin
              // non-positive pivot gives a zero diagonal
              if (d_pos) sq_start = 1'b1;
              else       w_we     = 1'b1;
            end else if (w_pos) begin
              div_start = 1'b1;
              div_num   = (NW'(t_mag) << 16) + NW'(w32[31:1]);
            end else begin
              w_we = 1'b1;
            end
          end
          PH_RECIP: begin
            if (w_pos) begin
              div_start = 1'b1;
              div_num   = (NW'(1) << 32) + NW'(w32[31:1]);
            end else begin
              w_we    = 1'b1;
              w_wdata = csls_pkg::SMAX32;
            end
          end
          default: ;
        endcase
      end
      S_DIV_WAIT: begin
        w_we    = div_done;
        w_wdata = div_sat;
      end
      S_SQRT_WAIT: begin
        w_we    = sq_done;
        w_wdata = 32'(sq_root);
      end
      S_FIN_MUL: begin
        w_we    = 1'b1;
        w_wdata = (y32 == csls_pkg::SMIN32) ? csls_pkg::SMAX32 : -y32;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_CHOL;
      a_q         <= '0;
      b_q         <= '0;
      k_q         <= '0;
      nm1_q       <= '0;
      size_q      <= 5'd16;
      err_q       <= 1'b0;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      prod_q      <= '0;
      out_valid_q <= 1'b0;
      index_q     <= '0;
      result_q    <= '0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      if (cfg_valid_i) size_q <= cfg_data_i;
      unique case (state_q)
        S_IDLE: begin
          if (accept && (cmd_i == csls_pkg::CMD_SOLVE)) begin
            nm1_q   <= csls_pkg::order_m1(size_q);
            err_q   <= 1'b0;
            phase_q <= PH_CHOL;
            a_q     <= '0;
            b_q     <= '0;
            state_q <= S_START;
          end
        end
        S_START: begin
          acc_q <= '0;
          unique case (phase_q)
            PH_CHOL: begin
              k_q     <= '0;
              // first column has an empty sum
              state_q <= (b_q == '0) ? S_FIN_RD : S_DOT_RD;
            end
            PH_RECIP: state_q <= S_FIN_RD;
            PH_INV: begin
              k_q     <= b_q;
              state_q <= S_DOT_RD;
            end
            PH_HINV: begin
              k_q     <= k_hinv;
              state_q <= S_DOT_RD;
            end
            PH_OUTP: begin
              k_q     <= '0;
              state_q <= S_DOT_RD;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_DOT_RD:  state_q <= S_DOT_MUL;
        S_DOT_MUL: begin
          prod_q  <= 64'(mul_a) * 64'(mul_b);
          state_q <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          acc_q <= acc_q + 64'(csls_pkg::qmul(prod_q));
          if (k_q == k_end) begin
            state_q <= S_FIN_RD;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_DOT_RD;
          end
        end
        S_FIN_RD: begin
          if (phase_q == PH_OUTP) begin
            out_valid_q <= 1'b1;
            index_q     <= 4'(a_q);
            result_q    <= csls_pkg::sat32(-acc_q);
            last_q      <= (a_q == nm1_q);
            state_q     <= S_NEXT;
          end else if (phase_q == PH_HINV) begin
            state_q <= S_NEXT;
          end else begin
            state_q <= S_FIN_EX;
          end
        end
        S_FIN_EX: begin
          unique case (phase_q)
            PH_CHOL: begin
              if (diag) begin
                if (d_pos) state_q <= S_SQRT_WAIT;
                else begin
                  err_q   <= 1'b1;
                  state_q <= S_NEXT;
                end
              end else if (w_pos) begin
                neg_q   <= t32[31];
                state_q <= S_DIV_WAIT;
              end else begin
                state_q <= S_NEXT;
              end
            end
            PH_RECIP: begin
              neg_q   <= 1'b0;
              state_q <= w_pos ? S_DIV_WAIT : S_NEXT;
            end
            PH_INV: begin
              prod_q  <= 64'(w32) * 64'(csls_pkg::sat32(acc_q));
              state_q <= S_FIN_MUL;
            end
            default: state_q <= S_NEXT;
          endcase
        end
        S_FIN_MUL:   state_q <= S_NEXT;
        S_DIV_WAIT:  if (div_done) state_q <= S_NEXT;
        S_SQRT_WAIT: if (sq_done) state_q <= S_NEXT;
        S_NEXT: begin
          state_q <= S_START;
          unique case (phase_q)
            PH_CHOL: begin
              if (!diag) b_q <= b_q + 1'b1;
              else if (a_q == nm1_q) begin
                phase_q <= PH_RECIP;
                a_q     <= '0;
              end else begin
                a_q <= a_q + 1'b1;
                b_q <= '0;
              end
            end
            PH_RECIP: begin
              if (a_q == nm1_q) begin
                // a one-element system has nothing below the diagonal
                phase_q <= (nm1_q == '0) ? PH_HINV : PH_INV;
                a_q     <= (nm1_q == '0) ? '0 : CW'(1);
                b_q     <= '0;
              end else begin
                a_q <= a_q + 1'b1;
              end
            end
            PH_INV: begin
              if (b_q != a_q - 1'b1) b_q <= b_q + 1'b1;
              else if (a_q == nm1_q) begin
                phase_q <= PH_HINV;
                a_q     <= '0;
                b_q     <= '0;
              end else begin
                a_q <= a_q + 1'b1;
                b_q <= '0;
              end
            end
            PH_HINV: begin
              if (b_q != nm1_q) b_q <= b_q + 1'b1;
              else if (a_q == nm1_q) begin
                phase_q <= PH_OUTP;
                a_q     <= '0;
                b_q     <= '0;
              end else begin
                a_q <= a_q + 1'b1;
                b_q <= '0;
              end
            end
            PH_OUTP: begin
              if (a_q == nm1_q) state_q <= S_IDLE;
              else              a_q     <= a_q + 1'b1;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // loaded matrix, never touched by a solve
  csls_ram #(.WIDTH(32), .DEPTH(csls_pkg::MAT_DEPTH)) u_mat (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(value_i),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  csls_ram #(.WIDTH(32), .DEPTH(csls_pkg::MAX_ORDER)) u_vec (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(value_i),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );

  // factor scratch, two copies written alike for two reads a cycle
  csls_ram #(.WIDTH(32), .DEPTH(csls_pkg::MAT_DEPTH)) u_work_a (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(wa_raddr), .rdata_o(wa_rdata)
  );

  csls_ram #(.WIDTH(32), .DEPTH(csls_pkg::MAT_DEPTH)) u_work_b (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(wb_raddr), .rdata_o(wb_rdata)
  );

  csls_ram #(.WIDTH(32), .DEPTH(csls_pkg::MAT_DEPTH)) u_hinv (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  csls_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(w32),
    .done_o(div_done), .quo_o(div_quo)
  );

  csls_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .rad_i(sq_rad),
    .done_o(sq_done), .root_o(sq_root)
  );

  assign out_valid_o    = out_valid_q;
  assign index_o        = index_q;
  assign result_value_o = result_q;
  assign last_o         = last_q;
  assign error_o        = err_q;

endmodule
